// ===== sv/swfrm_pkg.sv =====
// shared constants, types and helpers for the sliding window frame rate meter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package swfrm_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int IDX_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int TS_W       = 32;
  localparam int RATE_W     = 17;
  localparam int FRAMES_W   = 48;
  localparam int SMOOTH_W   = 40;
  localparam int ALPHA_W    = 9;
  localparam int MS_W       = 16;
  localparam int PROD_W     = SMOOTH_W + ALPHA_W;

  localparam logic [RATE_W-1:0]  RATE_MAX    = 17'h1FFFF;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam int                 SCALE_W     = 18;
  localparam logic [SCALE_W-1:0] RATE_SCALE  = 18'd256000;
  localparam int                 NUM_W       = CNT_W + SCALE_W;
  localparam int                 DCNT_W      = $clog2(NUM_W + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 2'd3;

  localparam logic REQ_FRAME = 1'b0;

  typedef struct packed {
    logic latch;
    logic pop;
    logic div_load;
    logic div_step;
    logic rate_plain;
    logic push;
    logic mul;
    logic ema;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic drop_ok;
    logic span_ok;
    logic div_last;
    logic is_frame;
    logic out_free;
  } status_t;

  function automatic logic [RATE_W-1:0] sat_rate(input logic [NUM_W-1:0] v);
    if (v > NUM_W'(RATE_MAX)) begin
      sat_rate = RATE_MAX;
    end else begin
      sat_rate = v[RATE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/swfrm_ctrl.sv =====
// sequencer for the frame rate meter: window drop loop, divide, frame update
// depends on swfrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module swfrm_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  swfrm_pkg::status_t status,
  output swfrm_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FRAME = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_EMA   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (status.drop_ok) begin
          cmd.pop   = 1'b1;
          state_nxt = S_READ;
        end else if (status.span_ok) begin
          cmd.div_load = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.rate_plain = 1'b1;
          state_nxt      = S_FRAME;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_FRAME;
        end
      end
      S_FRAME: begin
        if (status.is_frame) begin
          cmd.push  = 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMA;
      end
      S_EMA: begin
        cmd.ema   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_last) |=> (state_r == S_FRAME))
    else $error("divider exit not taken");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> (state_r == S_READ))
    else $error("accept outside idle");

  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.pop, cmd.div_load, cmd.rate_plain, cmd.push, cmd.load_out}))
    else $error("conflicting commands");

endmodule

`default_nettype wire

// ===== sv/swfrm_dp.sv =====
// datapath: stamp memory, window compare, restoring divider, interval filter,
// configuration and output registers; depends on swfrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module swfrm_dp (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  swfrm_pkg::cmd_t                        cmd,
  output swfrm_pkg::status_t                     status,
  input  wire                                    in_req_type,
  input  wire  [swfrm_pkg::TS_W-1:0]             in_timestamp_ms,
  input  wire                                    cfg_valid,
  input  wire  [swfrm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [swfrm_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic [swfrm_pkg::RATE_W-1:0]           out_rate_q8,
  output logic [swfrm_pkg::FRAMES_W-1:0]         out_frame_total,
  output logic [swfrm_pkg::TS_W-1:0]             out_last_interval_ms,
  output logic [swfrm_pkg::SMOOTH_W-1:0]         out_smoothed_interval_q8
);

  localparam int TS_W     = swfrm_pkg::TS_W;
  localparam int IDX_W    = swfrm_pkg::IDX_W;
  localparam int CNT_W    = swfrm_pkg::CNT_W;
  localparam int NUM_W    = swfrm_pkg::NUM_W;
  localparam int PROD_W   = swfrm_pkg::PROD_W;
  localparam int SMOOTH_W = swfrm_pkg::SMOOTH_W;
  localparam int ALPHA_W  = swfrm_pkg::ALPHA_W;
  localparam int MS_W     = swfrm_pkg::MS_W;
  localparam int RATE_W   = swfrm_pkg::RATE_W;
  localparam int FRAMES_W = swfrm_pkg::FRAMES_W;
  localparam int DCNT_W   = swfrm_pkg::DCNT_W;
  localparam int DEPTH    = swfrm_pkg::FIFO_DEPTH;

  // configuration
  logic [ALPHA_W-1:0] alpha_r;
  logic [MS_W-1:0]    window_r;
  logic [MS_W-1:0]    min_span_r;

  // item and state
  logic                 req_r;
  logic [TS_W-1:0]      now_r;
  logic [TS_W-1:0]      mem [DEPTH];
  logic [TS_W-1:0]      rdata_r;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TS_W-1:0]      prev_r;
  logic [TS_W-1:0]      interval_r;
  logic [SMOOTH_W-1:0]  smooth_r;
  logic [FRAMES_W-1:0]  frames_r;
  logic [RATE_W-1:0]    rate_r;
  logic [PROD_W-1:0]    prod_a_r, prod_b_r;

  // divider
  logic [TS_W-1:0]      divisor_r;
  logic [TS_W-1:0]      rem_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic [TS_W:0]        rem_sh;
  logic                 rem_ge;
  logic [NUM_W-1:0]     quo_nxt;

  logic [IDX_W-1:0]     head_inc;
  logic [CNT_W:0]       tail_sum;
  logic [IDX_W-1:0]     tail_idx;
  logic                 full;
  logic [ALPHA_W-1:0]   alpha_c;
  logic [PROD_W:0]      ema_sum;
  logic                 out_valid_r;

  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(count_r);
  assign tail_idx = (tail_sum >= (CNT_W + 1)'(DEPTH)) ?
                    IDX_W'(tail_sum - (CNT_W + 1)'(DEPTH)) : IDX_W'(tail_sum);
  assign full     = (count_r == CNT_W'(DEPTH));

  assign status.drop_ok  = (count_r != '0) &&
    (({1'b0, rdata_r} + (TS_W + 1)'(window_r)) < {1'b0, now_r});
  assign status.span_ok  = (count_r != '0) &&
    (({1'b0, rdata_r} + (TS_W + 1)'(min_span_r)) < {1'b0, now_r});
  assign status.div_last = (dcnt_r == DCNT_W'(1));
  assign status.is_frame = (req_r == swfrm_pkg::REQ_FRAME);
  assign status.out_free = !out_valid_r || out_ready;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, divisor_r});
  assign quo_nxt = {quo_r[NUM_W-2:0], rem_ge};

  assign alpha_c = (alpha_r > swfrm_pkg::ALPHA_ONE) ? swfrm_pkg::ALPHA_ONE : alpha_r;
  assign ema_sum = {1'b0, prod_a_r} + {1'b0, prod_b_r};

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - 1'b1;
    end else if (cmd.push) begin
      if (full) begin
        head_nxt = head_inc;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_idx] <= now_r;
    end
    rdata_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req_type;
      now_r <= in_timestamp_ms;
    end
    if (cmd.div_load) begin
      divisor_r <= now_r - rdata_r;
      rem_r     <= '0;
      quo_r     <= NUM_W'(count_r) * NUM_W'(swfrm_pkg::RATE_SCALE);
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? TS_W'(rem_sh - {1'b0, divisor_r}) : rem_sh[TS_W-1:0];
      quo_r <= quo_nxt;
    end
    if (cmd.mul) begin
      prod_a_r <= PROD_W'(smooth_r) * PROD_W'(alpha_c);
      prod_b_r <= PROD_W'({interval_r, 8'b0}) *
                  PROD_W'(swfrm_pkg::ALPHA_ONE - alpha_c);
    end
    if (cmd.load_out) begin
      out_rate_q8              <= rate_r;
      out_frame_total          <= frames_r;
      out_last_interval_ms     <= interval_r;
      out_smoothed_interval_q8 <= smooth_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= 9'd230;
      window_r    <= 16'd2000;
      min_span_r  <= 16'd500;
      head_r      <= '0;
      count_r     <= '0;
      prev_r      <= '0;
      interval_r  <= '0;
      smooth_r    <= '0;
      frames_r    <= '0;
      rate_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          swfrm_pkg::CFG_ALPHA:    alpha_r <= cfg_data[ALPHA_W-1:0];
          swfrm_pkg::CFG_INIT:     rate_r  <= cfg_data[RATE_W-1:0];
          swfrm_pkg::CFG_WINDOW:   window_r   <= cfg_data[MS_W-1:0];
          swfrm_pkg::CFG_MIN_SPAN: min_span_r <= cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.div_load) begin
        dcnt_r <= DCNT_W'(NUM_W);
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - 1'b1;
        if (status.div_last) begin
          rate_r <= swfrm_pkg::sat_rate(quo_nxt);
        end
      end
      if (cmd.rate_plain) begin
        rate_r <= swfrm_pkg::sat_rate(NUM_W'({count_r, 8'b0}));
      end
      if (cmd.push) begin
        interval_r <= now_r - prev_r;
        prev_r     <= now_r;
        frames_r   <= frames_r + 1'b1;
      end
      if (cmd.ema) begin
        smooth_r <= ema_sum[SMOOTH_W+7:8];
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("stamp count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (count_r == $past(count_r) - 1'b1))
    else $error("drop did not shrink the window");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !full) |=> (count_r == $past(count_r) + 1'b1))
    else $error("frame not stored");

  a_frames_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.push |=> $stable(frames_r))
    else $error("frame counter moved without a frame");

endmodule

`default_nettype wire

// ===== sv/sliding_window_frame_rate_meter.sv =====
// top level of the sliding window frame rate meter
// instantiates swfrm_ctrl and swfrm_dp; depends on swfrm_pkg
//
// in_valid/in_ready take one item: in_req_type (0 new frame, 1 rate update)
// and in_timestamp_ms. every item gives one result item on out_valid/out_ready:
// rate in Q8 fps, frame total, last interval and smoothed interval.
// cfg_valid/cfg_ready write one register per cycle (0 alpha, 1 initial rate,
// 2 window, 3 min span); cfg_ready is always high, write only while idle.
// one item at a time: the oldest stamp is read and compared until none is
// dropped, the rate is divided (restoring divider, one quotient bit per cycle)
// or formed plain, and a frame adds a push, a multiply and a filter update;
// each dropped stamp costs a memory read and a compare; the next item is
// taken in the cycle after the result is loaded.
// the result waits in an output register; a stalled receiver holds the block
// in its final step, and the next item is taken once the result moves on.
// synchronous reset clears counts, pointers and filters and restores register
// defaults; the stamp memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_frame_rate_meter (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_req_type,
  input  wire  [swfrm_pkg::TS_W-1:0]           in_timestamp_ms,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [swfrm_pkg::RATE_W-1:0]         out_rate_q8,
  output logic [swfrm_pkg::FRAMES_W-1:0]       out_frame_total,
  output logic [swfrm_pkg::TS_W-1:0]           out_last_interval_ms,
  output logic [swfrm_pkg::SMOOTH_W-1:0]       out_smoothed_interval_q8,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [swfrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [swfrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  swfrm_pkg::cmd_t    cmd;
  swfrm_pkg::status_t status;

  assign cfg_ready = 1'b1;

  swfrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  swfrm_dp u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .status                   (status),
    .in_req_type              (in_req_type),
    .in_timestamp_ms          (in_timestamp_ms),
    .cfg_valid                (cfg_valid),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_rate_q8              (out_rate_q8),
    .out_frame_total          (out_frame_total),
    .out_last_interval_ms     (out_last_interval_ms),
    .out_smoothed_interval_q8 (out_smoothed_interval_q8)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench for sliding_window_frame_rate_meter: directed and random item streams
// checked against a cycle-free model of the meter
// depends on swfrm_pkg and the meter rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int FIFO_DEPTH = swfrm_pkg::FIFO_DEPTH;
  localparam int TS_W       = swfrm_pkg::TS_W;
  localparam int RATE_W     = swfrm_pkg::RATE_W;
  localparam int FRAMES_W   = swfrm_pkg::FRAMES_W;
  localparam int SMOOTH_W   = swfrm_pkg::SMOOTH_W;
  localparam int ALPHA_W    = swfrm_pkg::ALPHA_W;
  localparam int MS_W       = swfrm_pkg::MS_W;
  localparam int CFG_IDX_W  = swfrm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = swfrm_pkg::CFG_DATA_W;

  localparam logic [RATE_W-1:0]    RATE_MAX     = swfrm_pkg::RATE_MAX;
  localparam logic [ALPHA_W-1:0]   ALPHA_ONE    = swfrm_pkg::ALPHA_ONE;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = swfrm_pkg::CFG_ALPHA;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT     = swfrm_pkg::CFG_INIT;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = swfrm_pkg::CFG_WINDOW;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = swfrm_pkg::CFG_MIN_SPAN;
  localparam logic                 REQ_FRAME    = swfrm_pkg::REQ_FRAME;

  localparam logic REQ_UPDATE = 1'b1;

  typedef struct {
    logic [RATE_W-1:0]   rate_q8;
    logic [FRAMES_W-1:0] frame_total;
    logic [TS_W-1:0]     last_interval_ms;
    logic [SMOOTH_W-1:0] smoothed_interval_q8;
  } meter_reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = 1'b0;
  logic [TS_W-1:0]       in_timestamp_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RATE_W-1:0]     out_rate_q8;
  logic [FRAMES_W-1:0]   out_frame_total;
  logic [TS_W-1:0]       out_last_interval_ms;
  logic [SMOOTH_W-1:0]   out_smoothed_interval_q8;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // meter model state
  logic [TS_W-1:0]       stamp_mem [FIFO_DEPTH];
  int unsigned           fifo_rd;
  int unsigned           fifo_cnt;
  logic [TS_W-1:0]       prev_frame;
  logic [SMOOTH_W-1:0]   ema_q8;
  logic [FRAMES_W-1:0]   frame_cnt;
  logic [RATE_W-1:0]     rate_now;
  logic [TS_W-1:0]       last_gap;
  logic [ALPHA_W-1:0]    alpha_reg;
  logic [RATE_W-1:0]     init_rate_reg;
  logic [MS_W-1:0]       window_reg;
  logic [MS_W-1:0]       min_span_reg;

  meter_reading_t pending_readings[$];
  int failures = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  sliding_window_frame_rate_meter i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_req_type              (in_req_type),
    .in_timestamp_ms          (in_timestamp_ms),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_rate_q8              (out_rate_q8),
    .out_frame_total          (out_frame_total),
    .out_last_interval_ms     (out_last_interval_ms),
    .out_smoothed_interval_q8 (out_smoothed_interval_q8),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic clear_meter_model();
    fifo_rd       = 0;
    fifo_cnt      = 0;
    prev_frame    = '0;
    ema_q8        = '0;
    frame_cnt     = '0;
    last_gap      = '0;
    alpha_reg     = 9'd230;
    init_rate_reg = '0;
    window_reg    = 16'd2000;
    min_span_reg  = 16'd500;
    rate_now      = init_rate_reg;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ALPHA: alpha_reg = data[ALPHA_W-1:0];
      CFG_INIT: begin
        init_rate_reg = data[RATE_W-1:0];
        rate_now      = init_rate_reg;
      end
      CFG_WINDOW: window_reg = data[MS_W-1:0];
      CFG_MIN_SPAN: min_span_reg = data[MS_W-1:0];
      default: ;
    endcase
  endtask

  // window drop, rate, then push and filter update for a frame
  task automatic predict_reading(input logic req, input logic [TS_W-1:0] ts);
    logic [63:0] now64;
    logic [63:0] span;
    logic [63:0] quotient;
    logic [63:0] weight;
    logic [63:0] sample;
    meter_reading_t got;
    now64 = 64'(ts);
    while (fifo_cnt > 0 && 64'(stamp_mem[fifo_rd]) + 64'(window_reg) < now64) begin
      fifo_rd = (fifo_rd + 1) % FIFO_DEPTH;
      fifo_cnt--;
    end
    if (fifo_cnt > 0 && 64'(stamp_mem[fifo_rd]) + 64'(min_span_reg) < now64) begin
      span     = now64 - 64'(stamp_mem[fifo_rd]);
      quotient = (64'(fifo_cnt) * 64'd256000) / span;
    end else begin
      quotient = 64'(fifo_cnt) << 8;
    end
    rate_now = (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
    if (req == REQ_FRAME) begin
      weight = (alpha_reg > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_reg);
      if (fifo_cnt >= FIFO_DEPTH) begin
        fifo_rd = (fifo_rd + 1) % FIFO_DEPTH;
        fifo_cnt--;
      end
      stamp_mem[(fifo_rd + fifo_cnt) % FIFO_DEPTH] = ts;
      fifo_cnt++;
      last_gap   = ts - prev_frame;
      sample     = 64'(last_gap) << 8;
      ema_q8     = SMOOTH_W'((64'(ema_q8) * weight + sample * (64'(ALPHA_ONE) - weight)) >> 8);
      prev_frame = ts;
      frame_cnt  = frame_cnt + 1'b1;
    end
    got.rate_q8              = rate_now;
    got.frame_total          = frame_cnt;
    got.last_interval_ms     = last_gap;
    got.smoothed_interval_q8 = ema_q8;
    pending_readings.push_back(got);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 47;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 47;
      end
      default: begin
        send_idle_pct  = 29;
        recv_stall_pct = 29;
      end
    endcase
  endtask

  task automatic send_item(input logic req, input logic [TS_W-1:0] ts);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_timestamp_ms <= ts;
    do @(posedge clk); while (!in_ready);
    predict_reading(req, ts);
  endtask

  // all readings back, then a wait for the block to go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic test_window_and_span();
    set_idling(0);
    send_item(REQ_UPDATE, 32'd5);
    send_item(REQ_FRAME, 32'd1000);
    send_item(REQ_FRAME, 32'd1040);
    send_item(REQ_FRAME, 32'd1080);
    send_item(REQ_UPDATE, 32'd1100);
    send_item(REQ_UPDATE, 32'd1500);
    send_item(REQ_UPDATE, 32'd1501);
    send_item(REQ_FRAME, 32'd1700);
    send_item(REQ_UPDATE, 32'd3000);
    send_item(REQ_UPDATE, 32'd3001);
    // time going backwards
    send_item(REQ_FRAME, 32'd1500);
    send_item(REQ_UPDATE, 32'd9000);
  endtask

  task automatic test_filter_weight();
    write_reg(CFG_ALPHA, 17'd0);
    write_reg(CFG_INIT, RATE_MAX);
    send_item(REQ_FRAME, 32'd20000);
    send_item(REQ_FRAME, 32'd20100);
    write_reg(CFG_ALPHA, 17'(ALPHA_ONE));
    send_item(REQ_FRAME, 32'd20150);
    write_reg(CFG_ALPHA, 17'h001FF);
    send_item(REQ_FRAME, 32'd20160);
    write_reg(CFG_ALPHA, 17'h1E12C);
    send_item(REQ_FRAME, 32'd20170);
    write_reg(CFG_INIT, 17'd0);
    write_reg(CFG_MIN_SPAN, 17'd0);
    write_reg(CFG_WINDOW, 17'd1);
    send_item(REQ_UPDATE, 32'd20180);
    // one ms span saturates the rate
    send_item(REQ_FRAME, 32'd20200);
    send_item(REQ_FRAME, 32'd20201);
    send_item(REQ_UPDATE, 32'd20201);
  endtask

  task automatic test_time_wrap();
    write_reg(CFG_ALPHA, 17'd230);
    write_reg(CFG_WINDOW, 17'd2000);
    write_reg(CFG_MIN_SPAN, 17'd500);
    send_item(REQ_FRAME, 32'hFFFF_FF00);
    send_item(REQ_FRAME, 32'hFFFF_FFFF);
    send_item(REQ_UPDATE, 32'hFFFF_FFFF);
    send_item(REQ_FRAME, 32'h0000_0010);
  endtask

  task automatic test_fifo_overflow();
    int n;
    logic [TS_W-1:0] t;
    write_reg(CFG_WINDOW, 17'h0FFFF);
    write_reg(CFG_MIN_SPAN, 17'($urandom_range(0, 200)));
    write_reg(CFG_ALPHA, 17'($urandom_range(0, 256)));
    t = 32'h20;
    for (n = 0; n < 300; n++) begin
      set_idling(n / 75);
      t = t + $urandom_range(0, 4);
      send_item((n % 16 == 15) ? REQ_UPDATE : REQ_FRAME, t);
    end
    // long gap empties a full store in one go
    t = t + 32'd70000;
    send_item(REQ_UPDATE, t);
    send_item(REQ_FRAME, t + 32'd3);
    send_item(REQ_FRAME, t + 32'd9);
  endtask

  task automatic test_random_streams();
    int ph;
    int n;
    int r;
    int unsigned win;
    int unsigned span;
    logic [TS_W-1:0] t;
    t = 32'h8000_0000 + $urandom_range(0, 32'h6FFF_FFFF);
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          win  = 65535;
          span = 0;
        end
        1: begin
          win  = 1;
          span = 65535;
        end
        default: begin
          win  = $urandom_range(20, 5000);
          span = $urandom_range(0, win);
        end
      endcase
      write_reg(CFG_ALPHA, {8'($urandom), 9'($urandom_range(0, 511))});
      write_reg(CFG_INIT, 17'($urandom));
      write_reg(CFG_WINDOW, {1'($urandom), 16'(win)});
      write_reg(CFG_MIN_SPAN, {1'($urandom), 16'(span)});
      set_idling(ph);
      for (n = 0; n < 110; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_item(1'($urandom), $urandom);
        end else begin
          case ($urandom_range(0, 9)) inside
            [0:4]: t = t + $urandom_range(0, 40);
            5: t = t + win + $urandom_range(0, 1);
            6: t = t + span + $urandom_range(0, 1);
            7: t = t + $urandom_range(0, win);
            8: t = t + $urandom_range(win, 3 * win + 3);
            default: t = t - $urandom_range(0, 30);
          endcase
          send_item((r < 20) ? REQ_UPDATE : REQ_FRAME, t);
        end
      end
    end
  endtask

  initial begin : result_check
    meter_reading_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          $error("result item with no reading pending");
          failures++;
        end else begin
          want = pending_readings.pop_front();
          if (out_rate_q8 !== want.rate_q8) begin
            $error("rate_q8: expected %0d, got %0d", want.rate_q8, out_rate_q8);
            failures++;
          end
          if (out_frame_total !== want.frame_total) begin
            $error("frame_total: expected %0d, got %0d", want.frame_total, out_frame_total);
            failures++;
          end
          if (out_last_interval_ms !== want.last_interval_ms) begin
            $error("last_interval_ms: expected %0d, got %0d", want.last_interval_ms,
                   out_last_interval_ms);
            failures++;
          end
          if (out_smoothed_interval_q8 !== want.smoothed_interval_q8) begin
            $error("smoothed_interval_q8: expected %0d, got %0d", want.smoothed_interval_q8,
                   out_smoothed_interval_q8);
            failures++;
          end
        end
      end
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : run_limit
    #(64'd60_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    clear_meter_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_window_and_span();
    test_filter_weight();
    test_time_wrap();
    test_fifo_overflow();
    test_random_streams();
    settle();
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/swfrm_pkg.sv
sv/swfrm_ctrl.sv
sv/swfrm_dp.sv
sv/sliding_window_frame_rate_meter.sv
bench/tb_top.sv
